>>> src/fbx_pkg.sv
// Package: shared constants, types and the microcode program of the frame builder.
`default_nettype none
package fbx_pkg;

  localparam int unsigned MAX_PAYLOAD   = 8;
  localparam int unsigned PAYLOAD_SLOTS = 8;
  localparam int unsigned LEN_W         = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned STEP_W        = 3;
  localparam logic [7:0]  START_RESET   = 8'hAA;

  typedef enum logic [2:0] {
    SRC_START = 3'd0,
    SRC_ID_LO = 3'd1,
    SRC_ID_HI = 3'd2,
    SRC_LEN   = 3'd3,
    SRC_PAY   = 3'd4,
    SRC_SEQ   = 3'd5,
    SRC_CHK   = 3'd6
  } src_e;

  typedef enum logic [1:0] {
    COND_NEXT     = 2'd0,
    COND_END      = 2'd1,
    COND_REM_ZERO = 2'd2,
    COND_REM_MORE = 2'd3
  } cond_e;

  localparam logic [STEP_W-1:0] STEP_START = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ID_LO = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ID_HI = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LEN   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_PAY   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_SEQ   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_CHK   = 3'd6;

  typedef struct packed {
    src_e              src;
    logic              xor_en;
    logic              pay_pop;
    logic              seq_inc;
    logic              last;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic   fire;
    ucode_t uc;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
    logic rem_zero;
    logic rem_one;
  } dp_stat_t;

  typedef struct packed {
    logic [15:0]                    msg_id;
    logic [7:0]                     payload_length;
    logic [PAYLOAD_SLOTS-1:0][7:0]  payload;
  } msg_t;

  // Control store: one word per program step.
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t uc;
    uc         = '0;
    uc.src     = SRC_CHK;
    uc.cond    = COND_END;
    uc.target  = STEP_START;
    case (step)
      STEP_START: begin
        uc.src  = SRC_START;
        uc.cond = COND_NEXT;
      end
      STEP_ID_LO: begin
        uc.src    = SRC_ID_LO;
        uc.xor_en = 1'b1;
        uc.cond   = COND_NEXT;
      end
      STEP_ID_HI: begin
        uc.src    = SRC_ID_HI;
        uc.xor_en = 1'b1;
        uc.cond   = COND_NEXT;
      end
      STEP_LEN: begin
        uc.src    = SRC_LEN;
        uc.xor_en = 1'b1;
        uc.cond   = COND_REM_ZERO;
        uc.target = STEP_SEQ;
      end
      STEP_PAY: begin
        uc.src     = SRC_PAY;
        uc.xor_en  = 1'b1;
        uc.pay_pop = 1'b1;
        uc.cond    = COND_REM_MORE;
        uc.target  = STEP_PAY;
      end
      STEP_SEQ: begin
        uc.src     = SRC_SEQ;
        uc.xor_en  = 1'b1;
        uc.seq_inc = 1'b1;
        uc.cond    = COND_NEXT;
      end
      STEP_CHK: begin
        uc.src  = SRC_CHK;
        uc.last = 1'b1;
        uc.cond = COND_END;
      end
      default: begin
        uc.src  = SRC_CHK;
        uc.last = 1'b1;
        uc.cond = COND_END;
      end
    endcase
    return uc;
  endfunction

endpackage
`default_nettype wire

>>> src/fbx_if.sv
// Interfaces: message input, frame byte output and start byte configuration channels.
`default_nettype none
interface fbx_msg_if;
  logic        valid;
  logic        ready;
  logic [15:0] msg_id;
  logic [7:0]  payload_length;
  logic [7:0]  payload_0;
  logic [7:0]  payload_1;
  logic [7:0]  payload_2;
  logic [7:0]  payload_3;
  logic [7:0]  payload_4;
  logic [7:0]  payload_5;
  logic [7:0]  payload_6;
  logic [7:0]  payload_7;

  modport source (
    output valid, msg_id, payload_length, payload_0, payload_1, payload_2, payload_3,
           payload_4, payload_5, payload_6, payload_7,
    input  ready
  );
  modport sink (
    input  valid, msg_id, payload_length, payload_0, payload_1, payload_2, payload_3,
           payload_4, payload_5, payload_6, payload_7,
    output ready
  );
endinterface

interface fbx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

interface fbx_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] start_byte;

  modport source (output valid, start_byte, input ready);
  modport sink (input valid, start_byte, output ready);
endinterface
`default_nettype wire

>>> src/frame_builder_xor_checksum_top.sv
// Top level: frame builder with XOR checksum, microcoded sequencer plus datapath.
//
//   channel    | dir | handshake        | payload
//   -----------+-----+------------------+-----------------------------------------------
//   in_msg     | in  | valid / ready    | msg_id[15:0], payload_length[7:0], payload_0..7
//   out_frame  | out | valid / ready    | frame_byte[7:0], last_byte
//   cfg        | in  | valid / ready    | start_byte[7:0] (ready is always high)
//
// A message becomes a frame of 6 + L bytes (L = length clamped to 8); one program step
// issues one byte per cycle into the single output register while out_frame is not
// stalled. The next message is taken in the cycle the checksum byte is loaded. A stall
// on out_frame freezes the program counter and the output byte.
// Reset clears the sequence number to 0 and loads the start byte with 0xAA.
`default_nettype none
module frame_builder_xor_checksum_top
  import fbx_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fbx_msg_if.sink   in_msg,
  fbx_byte_if.source out_frame,
  fbx_cfg_if.sink   cfg
);

  msg_t     msg;
  ctrl_t    ctrl;
  dp_stat_t stat;
  logic     take_ready;
  logic     accept;
  logic     cfg_we;

  // Gather the message fields into one word for the datapath.
  assign msg.msg_id         = in_msg.msg_id;
  assign msg.payload_length = in_msg.payload_length;
  assign msg.payload[0]     = in_msg.payload_0;
  assign msg.payload[1]     = in_msg.payload_1;
  assign msg.payload[2]     = in_msg.payload_2;
  assign msg.payload[3]     = in_msg.payload_3;
  assign msg.payload[4]     = in_msg.payload_4;
  assign msg.payload[5]     = in_msg.payload_5;
  assign msg.payload[6]     = in_msg.payload_6;
  assign msg.payload[7]     = in_msg.payload_7;

  assign in_msg.ready = take_ready;
  assign accept       = in_msg.valid && take_ready;

  // Users send configuration writes only while idle; not checked, so always take them.
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  fbx_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .take_ready_o(take_ready)
  );

  fbx_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .msg_i      (msg),
    .ctrl_i     (ctrl),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg.start_byte),
    .out_ready_i(out_frame.ready),
    .out_valid_o(out_frame.valid),
    .out_byte_o (out_frame.frame_byte),
    .out_last_o (out_frame.last_byte),
    .stat_o     (stat)
  );

endmodule
`default_nettype wire

>>> src/fbx_seq.sv
// Sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none
module fbx_seq
  import fbx_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire dp_stat_t stat_i,
  output ctrl_t         ctrl_o,
  output logic          take_ready_o
);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uc;
  logic              fire;

  assign uc   = ucode(step_q);
  assign fire = busy_q && stat_i.out_free;

  assign ctrl_o.fire = fire;
  assign ctrl_o.uc   = uc;

  // Take a new message when idle or while the closing byte is being issued.
  assign take_ready_o = !busy_q || (fire && (uc.cond == COND_END));

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (fire) begin
      case (uc.cond)
        COND_NEXT: step_d = step_q + STEP_W'(1);
        COND_END: begin
          busy_d = 1'b0;
          step_d = STEP_START;
        end
        COND_REM_ZERO: step_d = stat_i.rem_zero ? uc.target : step_q + STEP_W'(1);
        COND_REM_MORE: step_d = stat_i.rem_one ? step_q + STEP_W'(1) : uc.target;
        default: step_d = STEP_START;
      endcase
    end
    if (accept_i) begin
      busy_d = 1'b1;
      step_d = STEP_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_START;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

endmodule
`default_nettype wire

>>> src/fbx_dp.sv
// Datapath: message registers, checksum, sequence number and output register.
`default_nettype none
module fbx_dp
  import fbx_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire msg_t       msg_i,
  input  wire ctrl_t      ctrl_i,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output dp_stat_t        stat_o
);

  logic [7:0]                   start_q;
  logic [7:0]                   seq_q;
  logic [15:0]                  id_q;
  logic [LEN_W-1:0]             len_q;
  logic [LEN_W-1:0]             rem_q;
  logic [7:0]                   chk_q;
  logic [PAYLOAD_SLOTS-1:0][7:0] pay_q;
  logic                         ovalid_q;
  logic [7:0]                   obyte_q;
  logic                         olast_q;
  logic [LEN_W-1:0]             len_clamped;
  logic [7:0]                   byte_sel;

  assign len_clamped = (msg_i.payload_length > 8'(MAX_PAYLOAD)) ?
                       LEN_W'(MAX_PAYLOAD) : msg_i.payload_length[LEN_W-1:0];

  always_comb begin
    case (ctrl_i.uc.src)
      SRC_START: byte_sel = start_q;
      SRC_ID_LO: byte_sel = id_q[7:0];
      SRC_ID_HI: byte_sel = id_q[15:8];
      SRC_LEN:   byte_sel = 8'(len_q);
      SRC_PAY:   byte_sel = pay_q[0];
      SRC_SEQ:   byte_sel = seq_q;
      SRC_CHK:   byte_sel = chk_q;
      default:   byte_sel = chk_q;
    endcase
  end

  assign stat_o.out_free = !ovalid_q || out_ready_i;
  assign stat_o.rem_zero = (rem_q == '0);
  assign stat_o.rem_one  = (rem_q == LEN_W'(1));

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= START_RESET;
      seq_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_data_i;
      end
      if (ctrl_i.fire) begin
        ovalid_q <= 1'b1;
        if (ctrl_i.uc.seq_inc) begin
          seq_q <= seq_q + 8'd1;
        end
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      obyte_q <= byte_sel;
      olast_q <= ctrl_i.uc.last;
      if (ctrl_i.uc.xor_en) begin
        chk_q <= chk_q ^ byte_sel;
      end
      if (ctrl_i.uc.pay_pop) begin
        rem_q <= rem_q - LEN_W'(1);
        for (int i = 0; i < PAYLOAD_SLOTS - 1; i++) begin
          pay_q[i] <= pay_q[i+1];
        end
        pay_q[PAYLOAD_SLOTS-1] <= '0;
      end
    end
    // A new message lands when idle or in the cycle the previous checksum byte is loaded into the output register.
    if (accept_i) begin
      id_q  <= msg_i.msg_id;
      len_q <= len_clamped;
      rem_q <= len_clamped;
      chk_q <= '0;
      pay_q <= msg_i.payload;
    end
  end

endmodule
`default_nettype wire

>>> src/fbx_checker.sv
// Checker: port level assertions for the frame builder, bound to the top level.
`default_nettype none
module fbx_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] frame_byte_i,
  input wire logic       last_byte_i
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Hold a stalled frame byte.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(frame_byte_i)
                                       && $stable(last_byte_i)))
    else $error("stalled frame byte changed");

  // A stalled byte in mid frame blocks new messages.
  a_no_take_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i && !last_byte_i) |-> !in_ready_i)
    else $error("message taken while frame incomplete");

  // A message taken under a stalled output only follows a finished frame.
  a_take_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && out_valid_i && !out_ready_i) |-> last_byte_i)
    else $error("message taken before checksum byte");

  // No frame ends right after another: the next byte is a start byte.
  a_no_back_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_byte_i) |=> !(out_valid_i && last_byte_i))
    else $error("two checksum bytes in a row");

endmodule

bind frame_builder_xor_checksum_top fbx_checker u_fbx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_msg.valid),
  .in_ready_i  (in_msg.ready),
  .out_valid_i (out_frame.valid),
  .out_ready_i (out_frame.ready),
  .frame_byte_i(out_frame.frame_byte),
  .last_byte_i (out_frame.last_byte)
);
`default_nettype wire
